[rtl/ttm_pkg.sv]
package ttm_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int LIMIT_W     = 15;
	localparam int TRIP_W      = 4;
	localparam int CNT_W       = 16;
	localparam int SUM_W       = 32;
	localparam int CFG_DATA_W  = 15;
	localparam int OUT_DATA_W  = 88;
	localparam int DIV_CNT_W   = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd1280;
	localparam logic [TRIP_W-1:0]  TRIP_RESET  = 4'd3;
	localparam logic [TRIP_W-1:0]  RUN_MAX     = 4'd15;
	localparam logic [CNT_W-1:0]   CNT_MAX     = 16'hFFFF;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST  = 5'd31;

	localparam logic CFG_IDX_LIMIT = 1'b0;
	localparam logic CFG_IDX_TRIP  = 1'b1;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_REPORT = 1'b1
	} cmd_kind_t;

	typedef enum logic {
		BK_IDLE   = 1'b0,
		BK_DIVIDE = 1'b1
	} back_state_t;

	typedef struct packed {
		cmd_kind_t                   kind;
		logic signed [SAMPLE_W-1:0]  sample;
	} cmd_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] limit;
		logic [TRIP_W-1:0]  trip_length;
	} cfg_t;

	typedef struct packed {
		logic                        is_report;
		logic                        alert;
		logic [TRIP_W-1:0]           run_length;
		logic                        shutdown;
		logic                        ignored;
		logic [CNT_W-1:0]            reading_count;
		logic [CNT_W-1:0]            over_count;
		logic signed [SAMPLE_W-1:0]  max_seen;
		logic signed [SAMPLE_W-1:0]  min_seen;
		logic signed [SAMPLE_W-1:0]  mean;
		logic                        stats_valid;
	} res_t;

endpackage

[rtl/temperature_trip_monitor_top.sv]
// A sample transaction passes from the front hold register through the two-entry queue into the
// output register; the block sustains one sample per cycle unless the output stalls or a report
// is in the divider. A report with a nonzero reading count starts the serial divider for the mean,
// which resolves one quotient bit per cycle, and the back end pops no command until it is done.
// The asynchronous active-low reset clears the session statistics, the queue and the
// output valid flag, and returns limit to 1280 and trip length to 3.
module temperature_trip_monitor_top import ttm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [SAMPLE_W-1:0]   s_axis_tdata,  // sample
	input  logic                  s_axis_tuser,  // mode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// alert, run_length, shutdown, ignored, reading_count, over_count, max_seen,
	// min_seen, mean, stats_valid
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tuser,  // is_report
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic q_full;
	logic q_push;
	cmd_t q_push_cmd;
	logic q_pop;
	logic q_avail;
	cmd_t q_head;
	res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit       <= LIMIT_RESET;
			cfg_q.trip_length <= TRIP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_IDX_LIMIT) begin
				cfg_q.limit <= cfg_data;
			end else if (cfg_index == CFG_IDX_TRIP) begin
				cfg_q.trip_length <= cfg_data[TRIP_W-1:0];
			end
		end
	end

	ttm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (s_axis_tuser),
		.in_sample (s_axis_tdata),
		.q_full    (q_full),
		.push      (q_push),
		.push_cmd  (q_push_cmd)
	);

	ttm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.head     (q_head)
	);

	ttm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_avail   (q_avail),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res       (res),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready)
	);

	assign m_axis_tuser = res.is_report;
	assign m_axis_tdata = {res.stats_valid, res.mean, res.min_seen, res.max_seen,
		res.over_count, res.reading_count, res.ignored, res.shutdown,
		res.run_length, res.alert};

	a_ignored_needs_shutdown: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.ignored |-> res.shutdown && !res.alert && !res.is_report)
		else $error("An ignored sample was reported without a latched shutdown.");

	a_report_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.is_report |-> !res.alert && !res.ignored)
		else $error("A report transaction carries a sample flag.");

	a_alert_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.alert |-> res.run_length != '0 && res.over_count != '0)
		else $error("An alert was raised without an over-limit run.");

	a_stats_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> res.stats_valid == (res.reading_count != '0))
		else $error("Statistics valid flag disagrees with the reading count.");

endmodule

[rtl/ttm_front.sv]
module ttm_front import ttm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_mode,
	input  logic [SAMPLE_W-1:0] in_sample,
	input  logic                q_full,
	output logic                push,
	output cmd_t                push_cmd
);

	cmd_t hold_q;
	logic hold_v_q;

	assign push     = hold_v_q && !q_full;
	assign in_ready = !hold_v_q || !q_full;
	assign push_cmd = hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			hold_v_q <= 1'b1;
		end else if (push) begin
			hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			if (in_mode) begin
				hold_q.kind   <= CMD_REPORT;
				hold_q.sample <= '0;
			end else begin
				hold_q.kind   <= CMD_SAMPLE;
				hold_q.sample <= in_sample;
			end
		end
	end

endmodule

[rtl/ttm_queue.sv]
module ttm_queue import ttm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic avail,
	output cmd_t head
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[rtl/ttm_div.sv]
module ttm_div import ttm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [SUM_W-1:0]    dividend,
	input  logic [CNT_W-1:0]           divisor,
	output logic                       done,
	output logic signed [SAMPLE_W-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     den_q;
	logic [SUM_W-1:0]     dq_q;
	logic                 neg_q;
	logic [CNT_W:0]       trial;
	logic                 ge;

	assign trial    = {rem_q, dq_q[SUM_W-1]};
	assign ge       = (trial >= {1'b0, den_q});
	assign done     = done_q;
	assign quotient = neg_q ? -$signed(dq_q[SAMPLE_W-1:0]) : $signed(dq_q[SAMPLE_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == DIV_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			dq_q  <= dividend[SUM_W-1] ? (-dividend) : dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
			dq_q  <= {dq_q[SUM_W-2:0], ge};
		end
	end

endmodule

[rtl/ttm_back.sv]
module ttm_back import ttm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic q_avail,
	input  cmd_t q_head,
	output logic q_pop,
	output res_t res,
	output logic res_valid,
	input  logic res_ready
);

	back_state_t               state_q;
	back_state_t               state_nx;
	logic signed [SAMPLE_W-1:0] max_q;
	logic signed [SAMPLE_W-1:0] min_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           over_q;
	logic [TRIP_W-1:0]          run_q;
	logic                       tripped_q;
	res_t                       out_q;
	logic                       out_valid_q;

	logic                       slot_free;
	logic                       div_start;
	logic                       div_done;
	logic signed [SAMPLE_W-1:0] div_quot;

	logic signed [SAMPLE_W-1:0] max_nx;
	logic signed [SAMPLE_W-1:0] min_nx;
	logic signed [SUM_W-1:0]    sum_nx;
	logic [CNT_W-1:0]           count_nx;
	logic [CNT_W-1:0]           over_nx;
	logic [TRIP_W-1:0]          run_nx;
	logic                       tripped_nx;
	logic                       over_lim;
	res_t                       res_nx;

	ttm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign slot_free = !out_valid_q || res_ready;
	assign res       = out_q;
	assign res_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (div_start) begin
					state_nx = BK_DIVIDE;
				end
			end
			BK_DIVIDE: begin
				if (div_done) begin
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				q_pop     = q_avail && slot_free;
				div_start = q_pop && (q_head.kind == CMD_REPORT) && (count_q != '0);
			end
			BK_DIVIDE: begin
				q_pop     = 1'b0;
				div_start = 1'b0;
			end
			default: begin
				q_pop     = 1'b0;
				div_start = 1'b0;
			end
		endcase
	end

	always_comb begin
		max_nx     = max_q;
		min_nx     = min_q;
		sum_nx     = sum_q;
		count_nx   = count_q;
		over_nx    = over_q;
		run_nx     = run_q;
		tripped_nx = tripped_q;
		over_lim   = (q_head.sample > $signed({1'b0, cfg.limit}));

		res_nx.is_report = 1'b0;
		res_nx.alert     = 1'b0;
		res_nx.ignored   = 1'b0;
		res_nx.mean      = '0;

		if (q_head.kind == CMD_REPORT) begin
			res_nx.is_report = 1'b1;
			max_nx     = '0;
			min_nx     = '0;
			sum_nx     = '0;
			count_nx   = '0;
			over_nx    = '0;
			run_nx     = '0;
			tripped_nx = 1'b0;
		end else if (tripped_q) begin
			res_nx.ignored = 1'b1;
		end else begin
			if (count_q == '0) begin
				max_nx = q_head.sample;
				min_nx = q_head.sample;
			end else begin
				if (q_head.sample > max_q) begin
					max_nx = q_head.sample;
				end
				if (q_head.sample < min_q) begin
					min_nx = q_head.sample;
				end
			end
			if (count_q != CNT_MAX) begin
				sum_nx   = sum_q + SUM_W'(q_head.sample);
				count_nx = count_q + 1'b1;
			end
			if (over_lim) begin
				res_nx.alert = 1'b1;
				if (over_q != CNT_MAX) begin
					over_nx = over_q + 1'b1;
				end
				if (run_q != RUN_MAX) begin
					run_nx = run_q + 1'b1;
				end
				if (run_nx >= cfg.trip_length) begin
					tripped_nx = 1'b1;
				end
			end else begin
				run_nx = '0;
			end
		end

		if (q_head.kind == CMD_REPORT) begin
			res_nx.run_length    = run_q;
			res_nx.shutdown      = tripped_q;
			res_nx.reading_count = count_q;
			res_nx.over_count    = over_q;
			res_nx.max_seen      = max_q;
			res_nx.min_seen      = min_q;
			res_nx.stats_valid   = (count_q != '0);
		end else begin
			res_nx.run_length    = run_nx;
			res_nx.shutdown      = tripped_nx;
			res_nx.reading_count = count_nx;
			res_nx.over_count    = over_nx;
			res_nx.max_seen      = max_nx;
			res_nx.min_seen      = min_nx;
			res_nx.stats_valid   = (count_nx != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			max_q       <= '0;
			min_q       <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			over_q      <= '0;
			run_q       <= '0;
			tripped_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (q_pop) begin
				out_valid_q <= !div_start;
				max_q       <= max_nx;
				min_q       <= min_nx;
				sum_q       <= sum_nx;
				count_q     <= count_nx;
				over_q      <= over_nx;
				run_q       <= run_nx;
				tripped_q   <= tripped_nx;
			end else if (div_done) begin
				out_valid_q <= 1'b1;
			end else if (res_valid && res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= res_nx;
		end else if (div_done) begin
			out_q.mean <= div_quot;
		end
	end

endmodule
